@@ rtl/mtwd_pkg.sv @@
// ----------------------------------------------------------------------------
// mtwd_pkg
// Types, codes and helpers for the multi-channel watchdog core.
// ----------------------------------------------------------------------------
package mtwd_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdxW     = $clog2(MaxTasks);
  localparam int unsigned CntW     = IdxW + 1;

  localparam int unsigned InDataW  = 104;
  localparam int unsigned InUserW  = 6;
  localparam int unsigned OutDataW = 112;

  typedef enum logic [2:0] {
    REQ_REGISTER = 3'd0,
    REQ_ENABLE   = 3'd1,
    REQ_KICK     = 3'd2,
    REQ_CHECK    = 3'd3,
    REQ_CLEAR    = 3'd4,
    REQ_QUERY    = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    QRY_STATE   = 3'd0,
    QRY_REMAIN  = 3'd1,
    QRY_CHECKS  = 3'd2,
    QRY_TRANS   = 3'd3,
    QRY_RESETS  = 3'd4,
    QRY_COUNT   = 3'd5,
    QRY_TRIGGER = 3'd6
  } qry_e;

  typedef enum logic [2:0] {
    E_OK        = 3'd0,
    E_INVALID   = 3'd1,
    E_FULL      = 3'd2,
    E_NOT_FOUND = 3'd3,
    E_DISABLED  = 3'd4,
    E_LATCHED   = 3'd5,
    E_STATE     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LATE     = 2'd1,
    ST_STARVED  = 2'd2,
    ST_DISABLED = 2'd3
  } chan_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DIV,
    S_UPD,
    S_EVT,
    S_RPL
  } fsm_e;

  typedef struct packed {
    logic        rn;
    logic [31:0] mi;
    logic [31:0] el;
    logic [1:0]  prev;
    logic [1:0]  nxt;
    logic [3:0]  chan;
  } event_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

@@ rtl/multi_task_watchdog_core.sv @@
// ----------------------------------------------------------------------------
// multi_task_watchdog_core
// Supervises up to 16 channels; a check walks them with one serial divider.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// s_axis    in         request: tuser = type, query select; tdata = arguments
// m_axis    out        events, then one reply with tlast set
// cfg       in         reset_handler_present bit
//
// A plain request passes capture, execute and reply states. A check skips each
// idle channel and runs each overdue one through the restoring divider, the
// bottleneck, and an update.
// Events are buffered and sent after the walk. Reset clears counters and
// the latch; tables are written on registration. Output stalls hold the core.
// ----------------------------------------------------------------------------
module multi_task_watchdog_core
  import mtwd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // chan_sel[3:0] now_ms[35:4] period_ms[67:36] miss_limit[99:68]
  // auto_rst[100] enable_flag[101]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type[2:0] query_select[5:3]
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[2:0] chan_index[6:3] chan_state[8:7] from_state[10:9]
  // elapsed_time[42:11] misses[74:43] value[106:75] reset_now[107]
  // reset_latched[108] all_ok[109]
  output logic [OutDataW-1:0] m_axis_tdata,
  // kind[0]
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  fsm_e state_q, state_d;

  // captured request
  logic [2:0]  req_q, qs_q;
  logic [3:0]  ti_q;
  logic [31:0] now_q, dl_q, mm_q;
  logic        ar_q, en_q;

  // channel tables
  logic [31:0] dl_tab [MaxTasks];
  logic [31:0] lim_tab [MaxTasks];
  logic [31:0] kick_tab [MaxTasks];
  logic [31:0] miss_tab [MaxTasks];
  logic [1:0]  st_tab [MaxTasks];
  logic        en_tab [MaxTasks];
  logic        ar_tab [MaxTasks];

  logic [CntW-1:0] cnt_q, idx_q, ovd_q, evn_q, evr_q;
  logic            latch_q, rhp_q;
  logic [3:0]      trig_q;
  logic [31:0]     chk_q, trn_q, rst_q;
  logic [4:0]      bit_q;

  logic [31:0] rem_q, quo_q, el_q;
  event_t      ev_q [MaxTasks];

  logic [2:0]  rep_status_q;
  logic [3:0]  rep_ch_q;
  logic [1:0]  rep_cst_q;
  logic [31:0] rep_val_q;

  logic [IdxW-1:0] wi, ti;
  logic [31:0]     el_w, mis_w;
  logic [32:0]     div_t;
  logic [1:0]      prev_w, nxt_w;
  logic            walk_end, skip_w, rn_w, known, all_ok, recovered;

  assign wi    = idx_q[IdxW-1:0];
  assign ti    = ti_q[IdxW-1:0];
  assign known = {1'b0, ti_q} < cnt_q;

  always_comb begin
    el_w     = now_q - kick_tab[wi];
    walk_end = idx_q >= cnt_q;
    skip_w   = !en_tab[wi] || (el_w < dl_tab[wi]);
    div_t    = {rem_q, quo_q[31]};
    mis_w    = (quo_q > miss_tab[wi]) ? quo_q : miss_tab[wi];
    prev_w   = st_tab[wi];
    if (((lim_tab[wi] != 32'd0) && (mis_w >= lim_tab[wi])) || (prev_w == ST_STARVED)) begin
      nxt_w = ST_STARVED;
    end else begin
      nxt_w = ST_LATE;
    end
    rn_w = (nxt_w != prev_w) && (nxt_w == ST_STARVED) && ar_tab[wi];
  end

  always_comb begin
    all_ok    = 1'b1;
    recovered = 1'b1;
    for (int i = 0; i < MaxTasks; i++) begin
      if (CntW'(i) < cnt_q) begin
        if (en_tab[i] && st_tab[i] != ST_OK) all_ok = 1'b0;
        if (ar_tab[i] && (st_tab[i] == ST_LATE || st_tab[i] == ST_STARVED)) recovered = 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_EXEC;
      S_EXEC: begin
        if (req_q == REQ_CHECK && !latch_q) state_d = S_WALK;
        else state_d = S_RPL;
      end
      S_WALK: begin
        if (walk_end) state_d = S_EVT;
        else if (!skip_w) state_d = S_DIV;
      end
      S_DIV: if (bit_q == 5'd31) state_d = S_UPD;
      S_UPD: state_d = rn_w ? S_EVT : S_WALK;
      S_EVT: if (evr_q == evn_q) state_d = S_RPL;
      S_RPL: if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      latch_q <= 1'b0;
      trig_q  <= '0;
      chk_q   <= '0;
      trn_q   <= '0;
      rst_q   <= '0;
      rhp_q   <= 1'b1;
      idx_q   <= '0;
      ovd_q   <= '0;
      evn_q   <= '0;
      evr_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) rhp_q <= cfg_data_i;
      case (state_q)
        S_EXEC: begin
          idx_q <= '0;
          ovd_q <= '0;
          evn_q <= '0;
          evr_q <= '0;
          if (req_q == REQ_REGISTER && dl_q != 32'd0 && !(ar_q && (mm_q == 32'd0 || !rhp_q))
              && cnt_q < CntW'(MaxTasks)) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (req_q == REQ_CLEAR && latch_q && recovered) begin
            latch_q <= 1'b0;
            trig_q  <= '0;
          end
        end
        S_WALK: begin
          bit_q <= '0;
          if (walk_end) begin
            chk_q <= sat_inc(chk_q);
          end else if (skip_w) begin
            idx_q <= idx_q + 1'b1;
          end else begin
            ovd_q <= ovd_q + 1'b1;
          end
        end
        S_DIV: bit_q <= bit_q + 1'b1;
        S_UPD: begin
          idx_q <= idx_q + 1'b1;
          if (nxt_w != prev_w) begin
            evn_q <= evn_q + 1'b1;
            trn_q <= sat_inc(trn_q);
          end
          if (rn_w) begin
            latch_q <= 1'b1;
            trig_q  <= 4'(wi);
            rst_q   <= sat_inc(rst_q);
            chk_q   <= sat_inc(chk_q);
          end
        end
        S_EVT: if (evr_q != evn_q && m_axis_tready) evr_q <= evr_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath and tables
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_q <= s_axis_tuser[2:0];
          qs_q  <= s_axis_tuser[5:3];
          ti_q  <= s_axis_tdata[3:0];
          now_q <= s_axis_tdata[35:4];
          dl_q  <= s_axis_tdata[67:36];
          mm_q  <= s_axis_tdata[99:68];
          ar_q  <= s_axis_tdata[100];
          en_q  <= s_axis_tdata[101];
        end
      end
      S_EXEC: begin
        rep_status_q <= E_OK;
        rep_ch_q     <= '0;
        rep_cst_q    <= '0;
        rep_val_q    <= '0;
        unique case (req_q)
          REQ_REGISTER: begin
            if (dl_q == 32'd0 || (ar_q && (mm_q == 32'd0 || !rhp_q))) begin
              rep_status_q <= E_INVALID;
            end else if (cnt_q >= CntW'(MaxTasks)) begin
              rep_status_q <= E_FULL;
            end else begin
              dl_tab[cnt_q[IdxW-1:0]]   <= dl_q;
              lim_tab[cnt_q[IdxW-1:0]]  <= mm_q;
              ar_tab[cnt_q[IdxW-1:0]]   <= ar_q;
              kick_tab[cnt_q[IdxW-1:0]] <= now_q;
              miss_tab[cnt_q[IdxW-1:0]] <= '0;
              st_tab[cnt_q[IdxW-1:0]]   <= ST_OK;
              en_tab[cnt_q[IdxW-1:0]]   <= 1'b1;
              rep_ch_q                  <= 4'(cnt_q[IdxW-1:0]);
            end
          end
          REQ_ENABLE: begin
            rep_ch_q <= ti_q;
            if (!known) begin
              rep_status_q <= E_NOT_FOUND;
            end else if (!en_q) begin
              en_tab[ti] <= 1'b0;
              st_tab[ti] <= ST_DISABLED;
            end else if (!en_tab[ti]) begin
              kick_tab[ti] <= now_q;
              miss_tab[ti] <= '0;
              st_tab[ti]   <= ST_OK;
              en_tab[ti]   <= 1'b1;
            end
          end
          REQ_KICK: begin
            rep_ch_q <= ti_q;
            if (latch_q) rep_status_q <= E_LATCHED;
            else if (!known) rep_status_q <= E_NOT_FOUND;
            else if (!en_tab[ti]) rep_status_q <= E_DISABLED;
            else begin
              kick_tab[ti] <= now_q;
              miss_tab[ti] <= '0;
              st_tab[ti]   <= ST_OK;
            end
          end
          REQ_CHECK: if (latch_q) rep_status_q <= E_LATCHED;
          REQ_CLEAR: if (latch_q && !recovered) rep_status_q <= E_STATE;
          REQ_QUERY: begin
            case (qs_q) inside
              QRY_STATE, QRY_REMAIN: begin
                rep_ch_q <= ti_q;
                if (!known) rep_status_q <= E_NOT_FOUND;
                else if (qs_q == QRY_STATE) rep_cst_q <= st_tab[ti];
                else if (!en_tab[ti]) rep_status_q <= E_DISABLED;
                else if ((now_q - kick_tab[ti]) < dl_tab[ti]) begin
                  rep_val_q <= dl_tab[ti] - (now_q - kick_tab[ti]);
                end
              end
              QRY_CHECKS: rep_val_q <= chk_q;
              QRY_TRANS:  rep_val_q <= trn_q;
              QRY_RESETS: rep_val_q <= rst_q;
              QRY_COUNT:  rep_val_q <= 32'(cnt_q);
              QRY_TRIGGER: begin
                if (!latch_q) rep_status_q <= E_STATE;
                else begin
                  rep_ch_q  <= trig_q;
                  rep_val_q <= 32'(trig_q);
                end
              end
              default: rep_status_q <= E_INVALID;
            endcase
          end
          default: rep_status_q <= E_INVALID;
        endcase
      end
      S_WALK: begin
        rem_q <= '0;
        quo_q <= el_w;
        el_q  <= el_w;
        if (walk_end) rep_val_q <= 32'(ovd_q);
      end
      S_DIV: begin
        if (div_t >= {1'b0, dl_tab[wi]}) begin
          rem_q <= 32'(div_t - {1'b0, dl_tab[wi]});
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= div_t[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
      S_UPD: begin
        miss_tab[wi] <= mis_w;
        st_tab[wi]   <= nxt_w;
        if (nxt_w != prev_w) begin
          ev_q[evn_q[IdxW-1:0]] <= '{rn: rn_w, mi: mis_w, el: el_q, prev: prev_w,
                                     nxt: nxt_w, chan: 4'(wi)};
        end
        if (rn_w) rep_val_q <= 32'(ovd_q);
      end
      default: ;
    endcase
  end

  // output beat
  event_t ev_w;
  assign ev_w = ev_q[evr_q[IdxW-1:0]];

  always_comb begin
    m_axis_tvalid = 1'b0;
    m_axis_tuser  = 1'b0;
    m_axis_tlast  = 1'b0;
    m_axis_tdata  = '0;
    m_axis_tdata[108] = latch_q;
    if (state_q == S_EVT && evr_q != evn_q) begin
      m_axis_tvalid       = 1'b1;
      m_axis_tuser        = 1'b1;
      m_axis_tdata[6:3]   = ev_w.chan;
      m_axis_tdata[8:7]   = ev_w.nxt;
      m_axis_tdata[10:9]  = ev_w.prev;
      m_axis_tdata[42:11] = ev_w.el;
      m_axis_tdata[74:43] = ev_w.mi;
      m_axis_tdata[107]   = ev_w.rn;
    end else if (state_q == S_RPL) begin
      m_axis_tvalid        = 1'b1;
      m_axis_tlast         = 1'b1;
      m_axis_tdata[2:0]    = rep_status_q;
      m_axis_tdata[6:3]    = rep_ch_q;
      m_axis_tdata[8:7]    = rep_cst_q;
      m_axis_tdata[106:75] = rep_val_q;
      m_axis_tdata[109]    = all_ok;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("beat out while taking request");
  a_ev_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evr_q <= evn_q && evn_q <= CntW'(MaxTasks)) else $error("event buffer count");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTasks)) else $error("channel count overflow");
  a_latch_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(latch_q) |-> (rst_q != $past(rst_q)) || ($past(rst_q) == 32'hFFFF_FFFF))
    else $error("reset latched without count");

endmodule
